// ===== hw/rtl/mfd_pkg.sv =====
// Package for the message frame deframer: item types, result codes and
// frame layout constants. No dependencies.
`timescale 1ns / 1ps

package mfd_pkg;

    // Frame layout
    localparam int unsigned MinFrame   = 14;
    localparam int unsigned StampBytes = 8;
    localparam int unsigned BlenBytes  = 4;

    // Result kind codes
    localparam logic [1:0] KIND_SESS   = 2'd0;
    localparam logic [1:0] KIND_BODY   = 2'd1;
    localparam logic [1:0] KIND_RECORD = 2'd2;

    // Record status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_SHORT    = 2'd1;
    localparam logic [1:0] ST_MISMATCH = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_buffer;
    } mfd_in_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  out_byte;
        logic        run_last;
        logic [7:0]  msg_type;
        logic [63:0] stamp;
        logic [7:0]  sess_len;
        logic [31:0] body_len;
        logic [1:0]  status;
    } mfd_out_t;

    // Results produced by one accepted byte, in delivery order
    typedef struct packed {
        logic [1:0] count;
        mfd_out_t   res0;
        mfd_out_t   res1;
    } mfd_push_t;

endpackage

// ===== hw/rtl/mfd_parse.sv =====
// Frame parser: header field assembly, session/payload forwarding and the
// end-of-frame record. Depends on mfd_pkg.
`timescale 1ns / 1ps

module mfd_parse
    import mfd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      accept,
    input  mfd_in_t   in_item,
    output mfd_push_t push
);

    typedef enum logic [2:0] {
        PH_TYPE,
        PH_STAMP,
        PH_SLEN,
        PH_SESS,
        PH_BLEN,
        PH_BODY,
        PH_DONE
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [3:0]  field_count_reg, field_count_next;
    logic [3:0]  seen_count_reg, seen_count_next;
    logic [7:0]  type_hold_reg, type_hold_next;
    logic [63:0] stamp_acc_reg, stamp_acc_next;
    logic [7:0]  sess_len_hold_reg, sess_len_hold_next;
    logic [7:0]  sess_left_reg, sess_left_next;
    logic [31:0] body_len_acc_reg, body_len_acc_next;
    logic [31:0] body_left_reg, body_left_next;
    logic        excess_flag_reg, excess_flag_next;

    logic [3:0]  field_inc;
    logic        fwd;
    logic [1:0]  fwd_kind;
    logic        last;
    logic [1:0]  status;
    mfd_out_t    fwd_res;
    mfd_out_t    rec_res;

    assign field_inc = field_count_reg + 4'd1;
    assign last      = in_item.end_of_buffer;

    always_comb begin
        phase_next         = phase_reg;
        field_count_next   = field_count_reg;
        seen_count_next    = seen_count_reg;
        type_hold_next     = type_hold_reg;
        stamp_acc_next     = stamp_acc_reg;
        sess_len_hold_next = sess_len_hold_reg;
        sess_left_next     = sess_left_reg;
        body_len_acc_next  = body_len_acc_reg;
        body_left_next     = body_left_reg;
        excess_flag_next   = excess_flag_reg;
        fwd                = 1'b0;
        fwd_kind           = KIND_SESS;

        if (seen_count_reg < 4'(MinFrame)) begin
            seen_count_next = seen_count_reg + 4'd1;
        end

        unique case (phase_reg)
            PH_TYPE: begin
                type_hold_next   = in_item.data_byte;
                field_count_next = 4'd0;
                phase_next       = PH_STAMP;
            end
            PH_STAMP: begin
                stamp_acc_next   = {stamp_acc_reg[55:0], in_item.data_byte};
                field_count_next = field_inc;
                if (field_inc >= 4'(StampBytes)) begin
                    field_count_next = 4'd0;
                    phase_next       = PH_SLEN;
                end
            end
            PH_SLEN: begin
                sess_len_hold_next = in_item.data_byte;
                sess_left_next     = in_item.data_byte;
                phase_next = (in_item.data_byte != 8'd0) ? PH_SESS : PH_BLEN;
            end
            PH_SESS: begin
                fwd            = 1'b1;
                fwd_kind       = KIND_SESS;
                sess_left_next = sess_left_reg - 8'd1;
                if (sess_left_next == 8'd0) begin
                    phase_next = PH_BLEN;
                end
            end
            PH_BLEN: begin
                body_len_acc_next = {body_len_acc_reg[23:0], in_item.data_byte};
                field_count_next  = field_inc;
                if (field_inc >= 4'(BlenBytes)) begin
                    field_count_next = 4'd0;
                    body_left_next   = body_len_acc_next;
                    phase_next = (body_len_acc_next != 32'd0) ? PH_BODY : PH_DONE;
                end
            end
            PH_BODY: begin
                fwd            = 1'b1;
                fwd_kind       = KIND_BODY;
                body_left_next = body_left_reg - 32'd1;
                if (body_left_next == 32'd0) begin
                    phase_next = PH_DONE;
                end
            end
            default: begin
                // past the declared payload: drop and flag
                excess_flag_next = 1'b1;
            end
        endcase

        // status is judged on the state after this byte
        if (seen_count_next < 4'(MinFrame)) begin
            status = ST_SHORT;
        end else if (phase_next != PH_DONE || excess_flag_next) begin
            status = ST_MISMATCH;
        end else begin
            status = ST_OK;
        end

        fwd_res          = '0;
        fwd_res.kind     = fwd_kind;
        fwd_res.out_byte = in_item.data_byte;
        fwd_res.run_last = ~last;

        rec_res          = '0;
        rec_res.kind     = KIND_RECORD;
        rec_res.run_last = 1'b1;
        rec_res.msg_type = type_hold_next;
        rec_res.stamp    = stamp_acc_next;
        rec_res.sess_len = sess_len_hold_next;
        rec_res.body_len = body_len_acc_next;
        rec_res.status   = status;

        push = '0;
        if (fwd && last) begin
            push.count = 2'd2;
            push.res0  = fwd_res;
            push.res1  = rec_res;
        end else if (fwd) begin
            push.count = 2'd1;
            push.res0  = fwd_res;
        end else if (last) begin
            push.count = 2'd1;
            push.res0  = rec_res;
        end
        if (!accept) begin
            push.count = 2'd0;
        end

        // rearm after the record
        if (last) begin
            phase_next         = PH_TYPE;
            field_count_next   = 4'd0;
            seen_count_next    = 4'd0;
            type_hold_next     = 8'd0;
            stamp_acc_next     = 64'd0;
            sess_len_hold_next = 8'd0;
            sess_left_next     = 8'd0;
            body_len_acc_next  = 32'd0;
            body_left_next     = 32'd0;
            excess_flag_next   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_TYPE;
            field_count_reg   <= 4'd0;
            seen_count_reg    <= 4'd0;
            type_hold_reg     <= 8'd0;
            stamp_acc_reg     <= 64'd0;
            sess_len_hold_reg <= 8'd0;
            sess_left_reg     <= 8'd0;
            body_len_acc_reg  <= 32'd0;
            body_left_reg     <= 32'd0;
            excess_flag_reg   <= 1'b0;
        end else if (accept) begin
            phase_reg         <= phase_next;
            field_count_reg   <= field_count_next;
            seen_count_reg    <= seen_count_next;
            type_hold_reg     <= type_hold_next;
            stamp_acc_reg     <= stamp_acc_next;
            sess_len_hold_reg <= sess_len_hold_next;
            sess_left_reg     <= sess_left_next;
            body_len_acc_reg  <= body_len_acc_next;
            body_left_reg     <= body_left_next;
            excess_flag_reg   <= excess_flag_next;
        end
    end

endmodule

// ===== hw/rtl/mfd_outq.sv =====
// Four-entry result queue taking up to two results a cycle and giving one while m_ready is high.
// Depends on mfd_pkg.
`timescale 1ns / 1ps

module mfd_outq
    import mfd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  mfd_push_t push,
    output logic      room,
    output logic      m_valid,
    input  logic      m_ready,
    output mfd_out_t  m_data
);

    mfd_out_t   entry_reg [4];
    logic [1:0] wptr_reg, wptr_next;
    logic [1:0] rptr_reg, rptr_next;
    logic [2:0] count_reg, count_next;
    logic       pop;

    assign m_valid = (count_reg != 3'd0);
    assign m_data  = entry_reg[rptr_reg];
    assign pop     = m_valid && m_ready;
    // two free slots are always needed, whatever the byte turns out to be
    assign room    = (count_reg <= 3'd2);

    assign wptr_next  = wptr_reg + push.count;
    assign rptr_next  = rptr_reg + {1'b0, pop};
    assign count_next = count_reg + {1'b0, push.count} - {2'b00, pop};

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            entry_reg[wptr_reg] <= push.res0;
        end
        if (push.count == 2'd2) begin
            entry_reg[wptr_reg + 2'd1] <= push.res1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= 2'd0;
            rptr_reg  <= 2'd0;
            count_reg <= 3'd0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

endmodule

// ===== hw/rtl/message_frame_deframer.sv =====
// Message frame deframer top level: parser plus result queue.
// Depends on mfd_pkg, mfd_parse and mfd_outq.
`timescale 1ns / 1ps

// Usage:
//   s_ channel: one received byte per item (data_byte, end_of_buffer set on
//   the buffer's final byte). m_ channel: result items - forwarded session
//   bytes, forwarded payload bytes, and one end-of-frame record per buffer
//   carrying type, timestamp, session length, payload length and status.
//   Results are written into the result queue's registers and offered on
//   m_valid from there. Throughput: one byte per cycle while s_ready is
//   high; the two results of a final byte inside session or payload leave
//   one at a time through the single read port of the four-entry queue.
//   s_ready is high while the queue holds two or fewer results, so a byte is
//   taken even while an earlier result waits on a stalled receiver. When the
//   receiver stalls, the queue fills and s_ready drops; nothing is lost.
//   Reset (aresetn low, synchronous) empties the queue and puts the parser
//   back to expecting a type byte. After every record the parser rearms by
//   itself for the next frame.

module message_frame_deframer
    import mfd_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  mfd_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output mfd_out_t m_data
);

    mfd_push_t push;
    logic      room;
    logic      accept;

    assign s_ready = room;
    assign accept  = s_valid && room;

    // per-byte parse; results go straight into the queue
    mfd_parse u_parse (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .in_item (s_data),
        .push    (push)
    );

    // result registers and stall decoupling
    mfd_outq u_outq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .room    (room),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
